### rtl/jsu_pkg.sv
// Package for the JSON string unescaper: phase and segment types, status codes,
// character constants and the UTF-8, hex and escape decode helpers.
// No dependencies.
package jsu_pkg;

  // Most results one input item can cause.
  localparam int unsigned RES_MAX = 6;

  // Decoder phase within one quoted string.
  typedef enum logic [3:0] {
    PH_QUOTE    = 4'd0,
    PH_BODY     = 4'd1,
    PH_ESC      = 4'd2,
    PH_HEX1     = 4'd3,
    PH_HOLD     = 4'd4,
    PH_HOLD_BSL = 4'd5,
    PH_HEX2     = 4'd6
  } phase_e;

  // Result status codes.
  localparam logic [3:0] ST_BYTE     = 4'd0;
  localparam logic [3:0] ST_CLOSED   = 4'd1;
  localparam logic [3:0] ST_NO_QUOTE = 4'd2;
  localparam logic [3:0] ST_CONTROL  = 4'd3;
  localparam logic [3:0] ST_OPEN_ESC = 4'd4;
  localparam logic [3:0] ST_BAD_ESC  = 4'd5;
  localparam logic [3:0] ST_SHORT_U  = 4'd6;
  localparam logic [3:0] ST_BAD_HEX  = 4'd7;
  localparam logic [3:0] ST_OPEN_STR = 4'd8;

  // Source characters with a meaning of their own.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Surrogate ranges.
  localparam logic [15:0] HI_SURR_LO = 16'hD800;
  localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SURR_LO = 16'hDC00;
  localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // A run of up to four result items that share one status.
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0]      status;
    logic [3:0][7:0] bytes;
  } seg_t;

  localparam seg_t SEG_NONE = '{len: 3'd0, status: ST_BYTE, bytes: '0};

  // One result item.
  function automatic seg_t seg_single(input logic [7:0] b, input logic [3:0] st);
    seg_t s;
    s        = SEG_NONE;
    s.len    = 3'd1;
    s.status = st;
    s.bytes[0] = b;
    return s;
  endfunction

  // UTF-8 encoding of one code point.
  function automatic seg_t utf8_seg(input logic [20:0] cp);
    seg_t s;
    s = SEG_NONE;
    if (cp < 21'h80) begin
      s.len      = 3'd1;
      s.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      s.len      = 3'd2;
      s.bytes[0] = {3'b110, cp[10:6]};
      s.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      s.len      = 3'd3;
      s.bytes[0] = {4'b1110, cp[15:12]};
      s.bytes[1] = {2'b10, cp[11:6]};
      s.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      s.len      = 3'd4;
      s.bytes[0] = {5'b11110, cp[20:18]};
      s.bytes[1] = {2'b10, cp[17:12]};
      s.bytes[2] = {2'b10, cp[11:6]};
      s.bytes[3] = {2'b10, cp[5:0]};
    end
    return s;
  endfunction

  // Hex digit decode: bit 4 flags a non-hex character, bits 3:0 hold the value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = {1'b1, 4'd0};
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b0, d[3:0]};
    end
    return r;
  endfunction

  // Single-character escapes: bit 8 flags a known escape, bits 7:0 the byte.
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_QUOTE: r = {1'b1, CH_QUOTE};
      CH_BSL:   r = {1'b1, CH_BSL};
      CH_SLASH: r = {1'b1, CH_SLASH};
      8'h6E:    r = {1'b1, 8'h0A};
      8'h74:    r = {1'b1, 8'h09};
      8'h72:    r = {1'b1, 8'h0D};
      8'h62:    r = {1'b1, 8'h08};
      8'h66:    r = {1'b1, 8'h0C};
      default:  r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

endpackage

### rtl/json_string_unescaper_core.sv
// JSON string unescaper core: decodes a quoted JSON string to UTF-8 bytes.
// An item passes the input register, is decoded, and its results are loaded into the result register.
// Throughput: one item per cycle while items give at most one result and the sink is ready; an item
// with several results holds the output register until the sink has taken them all, one per cycle.
// Reset (rst_ni low, asynchronous) empties both registers and returns to waiting for a quote.
// Depends on jsu_pkg.
module json_string_unescaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // data_byte[7:0]
  input  logic       s_axis_tuser,  // mode[0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // out_byte[7:0]
  output logic [3:0] m_axis_tuser,  // status[3:0]
  output logic       m_axis_tlast
);
  import jsu_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic       mode_q;
  logic [7:0] byte_q;

  // Decoder state.
  phase_e      phase_q, phase_d;
  logic [15:0] cp_q, cp_d;
  logic [15:0] hs_q, hs_d;
  logic [2:0]  dig_q, dig_d;
  logic        bad_q, bad_d;

  // Result register: a burst of up to RES_MAX items drained one per cycle while the sink is ready.
  logic [RES_MAX-1:0][7:0] res_byte_q, res_byte_d;
  logic [RES_MAX-1:0][3:0] res_st_q, res_st_d;
  logic [2:0]              res_cnt_q, res_cnt_d;
  logic [2:0]              res_idx_q;

  logic out_take;
  logic burst_free;
  logic in_consume;

  // Handshakes.
  assign m_axis_tvalid = (res_idx_q != res_cnt_q);
  assign out_take      = m_axis_tvalid && m_axis_tready;
  assign burst_free    = !m_axis_tvalid || (out_take && (res_idx_q + 3'd1 == res_cnt_q));
  assign in_consume    = in_valid_q && burst_free;
  assign s_axis_tready = !in_valid_q || in_consume;

  assign m_axis_tdata = res_byte_q[res_idx_q];
  assign m_axis_tuser = res_st_q[res_idx_q];
  assign m_axis_tlast = (res_idx_q + 3'd1 == res_cnt_q);

  // Decode of one item into two segments and the next state.
  seg_t        seg_a, seg_b;
  seg_t        body_seg, esc_seg;
  phase_e      body_ph, esc_ph;
  logic        body_clr, esc_clr;
  logic [8:0]  esc_hit;
  logic [4:0]  hex_r;
  logic [15:0] cp_n;
  logic [2:0]  dig_n;
  logic        bad_n;
  logic [20:0] joined;
  logic        clr;

  // Plain string body byte.
  always_comb begin
    body_seg = SEG_NONE;
    body_ph  = PH_BODY;
    body_clr = 1'b0;
    if (byte_q == CH_QUOTE) begin
      body_seg = seg_single(8'h00, ST_CLOSED);
      body_clr = 1'b1;
    end else if (byte_q < CH_SPACE) begin
      body_seg = seg_single(8'h00, ST_CONTROL);
      body_clr = 1'b1;
    end else if (byte_q == CH_BSL) begin
      body_ph = PH_ESC;
    end else begin
      body_seg = seg_single(byte_q, ST_BYTE);
    end
  end

  // Byte after a backslash, other than the start of a \u escape.
  always_comb begin
    esc_hit = esc_map(byte_q);
    esc_ph  = PH_BODY;
    esc_clr = 1'b0;
    if (esc_hit[8]) begin
      esc_seg = seg_single(esc_hit[7:0], ST_BYTE);
    end else begin
      esc_seg = seg_single(8'h00, ST_BAD_ESC);
      esc_clr = 1'b1;
    end
  end

  // Hex digit accumulation and surrogate join.
  always_comb begin
    hex_r  = hex_decode(byte_q);
    cp_n   = {cp_q[11:0], hex_r[3:0]};
    dig_n  = dig_q + 3'd1;
    bad_n  = bad_q | hex_r[4];
    joined = SUPP_BASE + {1'b0, hs_q[9:0], cp_n[9:0]};
  end

  // Next state and result segments.
  always_comb begin
    phase_d = phase_q;
    cp_d    = cp_q;
    hs_d    = hs_q;
    dig_d   = dig_q;
    bad_d   = bad_q;
    seg_a   = SEG_NONE;
    seg_b   = SEG_NONE;
    clr     = 1'b0;
    if (mode_q) begin
      // End of input ends the run in every phase.
      clr = 1'b1;
      case (phase_q)
        PH_BODY:     seg_b = seg_single(8'h00, ST_OPEN_STR);
        PH_ESC:      seg_b = seg_single(8'h00, ST_OPEN_ESC);
        PH_HEX1,
        PH_HEX2:     seg_b = seg_single(8'h00, ST_SHORT_U);
        PH_HOLD: begin
          seg_a = utf8_seg({5'd0, hs_q});
          seg_b = seg_single(8'h00, ST_OPEN_STR);
        end
        PH_HOLD_BSL: begin
          seg_a = utf8_seg({5'd0, hs_q});
          seg_b = seg_single(8'h00, ST_OPEN_ESC);
        end
        default:     seg_b = seg_single(8'h00, ST_NO_QUOTE);
      endcase
    end else begin
      case (phase_q)
        PH_BODY: begin
          seg_b   = body_seg;
          phase_d = body_ph;
          clr     = body_clr;
        end
        PH_ESC: begin
          if (byte_q == CH_U) begin
            phase_d = PH_HEX1;
            cp_d    = '0;
            dig_d   = '0;
            bad_d   = 1'b0;
          end else begin
            seg_b   = esc_seg;
            phase_d = esc_ph;
            clr     = esc_clr;
          end
        end
        PH_HEX1,
        PH_HEX2: begin
          if (dig_n < 3'd4) begin
            cp_d  = cp_n;
            dig_d = dig_n;
            bad_d = bad_n;
          end else if (bad_n) begin
            seg_b = seg_single(8'h00, ST_BAD_HEX);
            clr   = 1'b1;
          end else begin
            cp_d  = '0;
            dig_d = '0;
            if (phase_q == PH_HEX1) begin
              if (cp_n >= HI_SURR_LO && cp_n <= HI_SURR_HI) begin
                hs_d    = cp_n;
                phase_d = PH_HOLD;
              end else begin
                phase_d = PH_BODY;
                seg_b   = utf8_seg({5'd0, cp_n});
              end
            end else begin
              // Second value after a held high surrogate.
              phase_d = PH_BODY;
              hs_d    = '0;
              if (cp_n >= LO_SURR_LO && cp_n <= LO_SURR_HI) begin
                seg_b = utf8_seg(joined);
              end else begin
                seg_a = utf8_seg({5'd0, hs_q});
                seg_b = utf8_seg({5'd0, cp_n});
              end
            end
          end
        end
        PH_HOLD: begin
          if (byte_q == CH_BSL) begin
            phase_d = PH_HOLD_BSL;
          end else begin
            seg_a   = utf8_seg({5'd0, hs_q});
            hs_d    = '0;
            seg_b   = body_seg;
            phase_d = body_ph;
            clr     = body_clr;
          end
        end
        PH_HOLD_BSL: begin
          if (byte_q == CH_U) begin
            phase_d = PH_HEX2;
            cp_d    = '0;
            dig_d   = '0;
            bad_d   = 1'b0;
          end else begin
            seg_a   = utf8_seg({5'd0, hs_q});
            hs_d    = '0;
            seg_b   = esc_seg;
            phase_d = esc_ph;
            clr     = esc_clr;
          end
        end
        default: begin
          // Waiting for the opening quote.
          if (byte_q == CH_QUOTE) begin
            phase_d = PH_BODY;
            cp_d    = '0;
            hs_d    = '0;
            dig_d   = '0;
            bad_d   = 1'b0;
          end else begin
            seg_b = seg_single(8'h00, ST_NO_QUOTE);
            clr   = 1'b1;
          end
        end
      endcase
    end
    // A terminal status returns the decoder to waiting for a quote.
    if (clr) begin
      phase_d = PH_QUOTE;
      cp_d    = '0;
      hs_d    = '0;
      dig_d   = '0;
      bad_d   = 1'b0;
    end
  end

  // Merge the two segments into one burst.
  always_comb begin
    logic [2:0] iv;
    logic [2:0] jv;
    res_cnt_d = seg_a.len + seg_b.len;
    for (int i = 0; i < RES_MAX; i++) begin
      iv = 3'(i);
      jv = iv - seg_a.len;
      if (iv < seg_a.len) begin
        res_byte_d[i] = seg_a.bytes[iv[1:0]];
        res_st_d[i]   = ST_BYTE;
      end else begin
        res_byte_d[i] = seg_b.bytes[jv[1:0]];
        res_st_d[i]   = seg_b.status;
      end
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  // Decoder state and burst control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_QUOTE;
      cp_q      <= '0;
      hs_q      <= '0;
      dig_q     <= '0;
      bad_q     <= 1'b0;
      res_cnt_q <= '0;
      res_idx_q <= '0;
    end else if (in_consume) begin
      phase_q   <= phase_d;
      cp_q      <= cp_d;
      hs_q      <= hs_d;
      dig_q     <= dig_d;
      bad_q     <= bad_d;
      res_cnt_q <= res_cnt_d;
      res_idx_q <= '0;
    end else if (out_take) begin
      res_idx_q <= res_idx_q + 3'd1;
    end
  end

  // Burst payload.
  always_ff @(posedge clk_i) begin
    if (in_consume) begin
      res_byte_q <= res_byte_d;
      res_st_q   <= res_st_d;
    end
  end

endmodule

### verif/json_string_unescaper_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the JSON string unescaper: watches both stream channels, decodes each
// accepted source item itself and compares every result transfer with the oldest one due.
// Depends on jsu_pkg for the phase type, status codes and character constants.
module json_string_unescaper_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,     // data_byte[7:0]
  input  logic        s_tuser_i,     // mode[0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,     // out_byte[7:0]
  input  logic [3:0]  m_tuser_i,     // status[3:0]
  input  logic        m_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       last;
  } result_t;

  result_t     due_q[$];
  result_t     item_q[$];
  result_t     got;
  result_t     want;
  int unsigned fails;

  // Decoder state as the block should hold it.
  phase_e      ph;
  logic [15:0] cp_acc;
  logic [15:0] hi_surr;
  logic [2:0]  nhex;
  logic        bad_hex;

  function automatic void emit(input logic [7:0] b, input logic [3:0] st);
    item_q.push_back('{out_byte: b, status: st, last: 1'b0});
  endfunction

  // A terminal status ends the run and puts the decoder back to waiting for a quote.
  function automatic void close_run(input logic [3:0] st);
    ph      = PH_QUOTE;
    cp_acc  = '0;
    hi_surr = '0;
    nhex    = '0;
    bad_hex = 1'b0;
    emit(8'h00, st);
  endfunction

  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], ST_BYTE);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]}, ST_BYTE);
      emit({2'b10, cp[5:0]}, ST_BYTE);
    end else if (cp < SUPP_BASE) begin
      emit({4'b1110, cp[15:12]}, ST_BYTE);
      emit({2'b10, cp[11:6]}, ST_BYTE);
      emit({2'b10, cp[5:0]}, ST_BYTE);
    end else begin
      emit({5'b11110, cp[20:18]}, ST_BYTE);
      emit({2'b10, cp[17:12]}, ST_BYTE);
      emit({2'b10, cp[11:6]}, ST_BYTE);
      emit({2'b10, cp[5:0]}, ST_BYTE);
    end
  endfunction

  function automatic void body_char(input logic [7:0] c);
    ph = PH_BODY;
    if (c == CH_QUOTE) begin
      close_run(ST_CLOSED);
    end else if (c < CH_SPACE) begin
      close_run(ST_CONTROL);
    end else if (c == CH_BSL) begin
      ph = PH_ESC;
    end else begin
      emit(c, ST_BYTE);
    end
  endfunction

  // Character after a backslash; the second flag marks the \u that may close a pair.
  function automatic void escape_char(input logic [7:0] c, input bit second);
    logic [7:0] r;
    bit         known;
    known = 1'b1;
    case (c)
      CH_QUOTE: r = CH_QUOTE;
      CH_BSL:   r = CH_BSL;
      CH_SLASH: r = CH_SLASH;
      "n":      r = 8'h0A;
      "t":      r = 8'h09;
      "r":      r = 8'h0D;
      "b":      r = 8'h08;
      "f":      r = 8'h0C;
      default: begin
        r     = 8'h00;
        known = 1'b0;
      end
    endcase
    if (c == CH_U) begin
      ph      = second ? PH_HEX2 : PH_HEX1;
      cp_acc  = '0;
      nhex    = '0;
      bad_hex = 1'b0;
    end else if (!known) begin
      close_run(ST_BAD_ESC);
    end else begin
      ph = PH_BODY;
      emit(r, ST_BYTE);
    end
  endfunction

  // Works out every result one source item causes and queues them behind the older ones.
  function automatic void decode_item(input logic mode, input logic [7:0] c);
    logic [7:0]  d;
    logic [3:0]  nib;
    logic [15:0] val;
    logic [20:0] joined;
    item_q.delete();
    if (mode) begin
      case (ph)
        PH_BODY:          close_run(ST_OPEN_STR);
        PH_ESC:           close_run(ST_OPEN_ESC);
        PH_HEX1, PH_HEX2: close_run(ST_SHORT_U);
        PH_HOLD: begin
          emit_utf8({5'd0, hi_surr});
          close_run(ST_OPEN_STR);
        end
        PH_HOLD_BSL: begin
          emit_utf8({5'd0, hi_surr});
          close_run(ST_OPEN_ESC);
        end
        default:          close_run(ST_NO_QUOTE);
      endcase
    end else begin
      case (ph)
        PH_BODY: body_char(c);
        PH_ESC:  escape_char(c, 1'b0);
        PH_HEX1, PH_HEX2: begin
          // Any byte counts as a digit; a non-hex one only flags the escape.
          nib = 4'd0;
          if (c >= "0" && c <= "9") begin
            d   = c - "0";
            nib = d[3:0];
          end else if (c >= "a" && c <= "f") begin
            d   = c - "a" + 8'd10;
            nib = d[3:0];
          end else if (c >= "A" && c <= "F") begin
            d   = c - "A" + 8'd10;
            nib = d[3:0];
          end else begin
            bad_hex = 1'b1;
          end
          cp_acc = {cp_acc[11:0], nib};
          nhex   = nhex + 3'd1;
          if (nhex == 3'd4) begin
            if (bad_hex) begin
              close_run(ST_BAD_HEX);
            end else begin
              val    = cp_acc;
              nhex   = '0;
              cp_acc = '0;
              if (ph == PH_HEX1) begin
                if (val >= HI_SURR_LO && val <= HI_SURR_HI) begin
                  hi_surr = val;
                  ph      = PH_HOLD;
                end else begin
                  ph = PH_BODY;
                  emit_utf8({5'd0, val});
                end
              end else begin
                ph = PH_BODY;
                if (val >= LO_SURR_LO && val <= LO_SURR_HI) begin
                  joined = SUPP_BASE + (({5'd0, hi_surr} - {5'd0, HI_SURR_LO}) << 10)
                         + ({5'd0, val} - {5'd0, LO_SURR_LO});
                  hi_surr = '0;
                  emit_utf8(joined);
                end else begin
                  // Not a pair: both values go out raw, the second one is never held.
                  emit_utf8({5'd0, hi_surr});
                  hi_surr = '0;
                  emit_utf8({5'd0, val});
                end
              end
            end
          end
        end
        PH_HOLD: begin
          if (c == CH_BSL) begin
            ph = PH_HOLD_BSL;
          end else begin
            emit_utf8({5'd0, hi_surr});
            hi_surr = '0;
            body_char(c);
          end
        end
        PH_HOLD_BSL: begin
          if (c == CH_U) begin
            escape_char(c, 1'b1);
          end else begin
            emit_utf8({5'd0, hi_surr});
            hi_surr = '0;
            escape_char(c, 1'b0);
          end
        end
        default: begin
          if (c == CH_QUOTE) begin
            cp_acc  = '0;
            hi_surr = '0;
            nhex    = '0;
            bad_hex = 1'b0;
            ph      = PH_BODY;
          end else begin
            close_run(ST_NO_QUOTE);
          end
        end
      endcase
    end
    if (item_q.size() > 0) begin
      item_q[item_q.size() - 1].last = 1'b1;
    end
    foreach (item_q[i]) begin
      due_q.push_back(item_q[i]);
    end
  endfunction

  // Results are checked before the source transfer of the same edge is decoded.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q.delete();
      fails        = 0;
      ph           = PH_QUOTE;
      cp_acc       = '0;
      hi_surr      = '0;
      nhex         = '0;
      bad_hex      = 1'b0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = '{out_byte: m_tdata_i, status: m_tuser_i, last: m_tlast_i};
        if (due_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual byte %h status %0d last %0d",
                   $time, got.out_byte, got.status, got.last);
        end else begin
          want = due_q.pop_front();
          if (got.out_byte !== want.out_byte || got.status !== want.status ||
              got.last !== want.last) begin
            fails++;
            $display({"%0t: result differs, expected byte %h status %0d last %0d, ",
                      "actual byte %h status %0d last %0d"},
                     $time, want.out_byte, want.status, want.last,
                     got.out_byte, got.status, got.last);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        decode_item(s_tuser_i, s_tdata_i);
      end
      fail_count_o <= fails;
      pending_o    <= due_q.size();
    end
  end

endmodule

### verif/json_string_unescaper_core_test.sv
`timescale 1ns / 1ps
// Top of the unescaper testbench: clock, reset, source stimulus and sink back-pressure,
// with the verdict taken from the scoreboard. Depends on jsu_pkg, the core and the checker.
module json_string_unescaper_core_test;
  import jsu_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // data_byte[7:0]
  logic        s_axis_tuser  = 1'b0;   // mode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // out_byte[7:0]
  logic [3:0]  m_axis_tuser;           // status[3:0]
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;

  json_string_unescaper_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  json_string_unescaper_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Sink back-pressure at the rate of the current stage.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One source transfer, after an optional random gap.
  task automatic send_item(input logic mode, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(1'b0, s[i]);
    end
  endtask

  // Up to four hex digits of v in mixed case; spoil swaps one of them for a non-hex byte.
  task automatic send_hex(input logic [15:0] v, input int ndig, input bit spoil);
    int         bad_pos;
    logic [7:0] c;
    logic [3:0] nib;
    bad_pos = spoil ? $urandom_range(ndig - 1) : -1;
    for (int i = 0; i < ndig; i++) begin
      nib = v[15 - 4 * i -: 4];
      if (i == bad_pos) begin
        do c = 8'($urandom_range(255));
        while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
      end else if (nib < 4'd10) begin
        c = 8'h30 + nib;
      end else if ($urandom_range(1)) begin
        c = 8'h61 + nib - 8'd10;
      end else begin
        c = 8'h41 + nib - 8'd10;
      end
      send_item(1'b0, c);
    end
  endtask

  task automatic send_u(input logic [15:0] v);
    send_item(1'b0, CH_BSL);
    send_item(1'b0, CH_U);
    send_hex(v, 4, 1'b0);
  endtask

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(7))
      0:       return CH_QUOTE;
      1:       return CH_BSL;
      2:       return CH_SLASH;
      3:       return "n";
      4:       return "t";
      5:       return "r";
      6:       return "b";
      default: return "f";
    endcase
  endfunction

  function automatic logic [15:0] pick_high();
    return 16'($urandom_range(HI_SURR_HI, HI_SURR_LO));
  endfunction

  // One quoted string with random content and a random ending, most of them clean.
  task automatic send_run();
    logic [7:0]  c;
    logic [15:0] v;
    send_item(1'b0, CH_QUOTE);
    repeat ($urandom_range(6)) begin
      case ($urandom_range(7))
        0, 1: begin
          do c = 8'($urandom_range(255, 32));
          while (c == CH_QUOTE || c == CH_BSL);
          send_item(1'b0, c);
        end
        2: begin
          send_item(1'b0, CH_BSL);
          send_item(1'b0, pick_escape());
        end
        3: begin
          // One, two or three byte UTF-8, lone low surrogates and lone highs included.
          case ($urandom_range(2))
            0:       v = 16'($urandom_range(16'h007F));
            1:       v = 16'($urandom_range(16'h07FF, 16'h0080));
            default: v = 16'($urandom_range(16'hFFFF, 16'h0800));
          endcase
          send_u(v);
        end
        4: begin
          send_u(pick_high());
          send_u(16'($urandom_range(LO_SURR_HI, LO_SURR_LO)));
        end
        5: begin
          // High surrogate followed by \u that is not a low one.
          send_u(pick_high());
          if ($urandom_range(1)) begin
            v = pick_high();
          end else begin
            do v = 16'($urandom_range(16'hFFFF));
            while (v inside {[LO_SURR_LO:LO_SURR_HI]});
          end
          send_u(v);
        end
        6: begin
          send_u(pick_high());
          send_item(1'b0, CH_BSL);
          send_item(1'b0, pick_escape());
        end
        default: send_u(pick_high());
      endcase
    end
    case ($urandom_range(19))
      12: send_item(1'b1, 8'($urandom_range(255)));
      13: send_item(1'b0, 8'($urandom_range(31)));
      14: begin
        send_item(1'b0, CH_BSL);
        do c = 8'($urandom_range(255));
        while (c inside {CH_QUOTE, CH_BSL, CH_SLASH, "n", "t", "r", "b", "f", CH_U});
        send_item(1'b0, c);
      end
      15: begin
        send_item(1'b0, CH_BSL);
        send_item(1'b1, 8'($urandom_range(255)));
      end
      16: begin
        send_item(1'b0, CH_BSL);
        send_item(1'b0, CH_U);
        send_hex(16'($urandom_range(16'hFFFF)), $urandom_range(3), 1'b0);
        send_item(1'b1, 8'($urandom_range(255)));
      end
      17: begin
        send_item(1'b0, CH_BSL);
        send_item(1'b0, CH_U);
        send_hex(16'($urandom_range(16'hFFFF)), 4, 1'b1);
      end
      18: begin
        send_u(pick_high());
        send_item(1'b1, 8'($urandom_range(255)));
      end
      19: begin
        send_u(pick_high());
        send_item(1'b0, CH_BSL);
        send_item(1'b1, 8'($urandom_range(255)));
      end
      default: send_item(1'b0, CH_QUOTE);
    endcase
  endtask

  // Stop offering items until the sink has taken every result still due.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stage_start;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: quote missing at end of input and on a zero byte, top byte passed raw,
    // largest BMP escape, control character, then the largest surrogate pair.
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, CH_QUOTE);
    send_item(1'b0, 8'hFF);
    send_text("\\uFfFf");
    send_item(1'b0, 8'h1F);
    send_text("\"\\uDBFF\\uDFFF\"");

    // Random strings with some noise between them, in three back-pressure stages.
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      stage_start = items_sent;
      while (items_sent - stage_start < 110) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(3, 1)) begin
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
          end
        end else begin
          send_run();
        end
      end
      drain();
    end

    repeat (12) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("json_string_unescaper_core: match");
    end else begin
      $display("json_string_unescaper_core: mismatch");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("json_string_unescaper_core: mismatch");
    $finish;
  end

endmodule
